FILE: design/crc_pkg.sv
// Shared constants, types and the divide-by-divisor digit step for the cycle ratio charger.
package crc_pkg;

  localparam int CountWidth    = 64;
  localparam int ClockDivisor  = 12;
  localparam int FallbackTicks = 8;

  localparam int AddrW     = 3;
  localparam int DigitW    = 16;
  localparam int NumDigits = 64 / DigitW;
  localparam int RemW      = $clog2(ClockDivisor + 1);
  localparam int StepW     = RemW + DigitW;

  localparam logic [63:0] CntMask    = (64'd1 << CountWidth) - 64'd1;
  localparam logic [63:0] FbTimeInc  = 64'(FallbackTicks);
  localparam logic [63:0] FbClockInc = 64'(FallbackTicks * ClockDivisor);
  localparam logic [31:0] RatioReset = 32'd12;

  // ceil(2^32 / divisor): exact quotient for any dividend below 2^24
  localparam logic [32:0] DivRecip =
    33'(((65'd1 << 32) + 65'(ClockDivisor) - 65'd1) / 65'(ClockDivisor));

  typedef struct packed {
    logic [DigitW-1:0] q;
    logic [RemW-1:0]   r;
  } div_step_t;

  // per-word sideband carried alongside the divider stages
  typedef struct packed {
    logic            fb;
    logic [63:0]     delta;
    logic            d_hi;
    logic [RemW-1:0] d_neg;
    logic            p_hi;
    logic [RemW-1:0] p_neg;
  } side_t;

  function automatic div_step_t div_step(input logic [RemW-1:0] rin,
                                         input logic [DigitW-1:0] dig);
    logic [StepW-1:0]    x;
    logic [StepW+32:0]   prod;
    logic [StepW-1:0]    qw;
    logic [StepW-1:0]    back;
    div_step_t           res;
    x    = {rin, dig};
    prod = (StepW + 33)'(x) * (StepW + 33)'(DivRecip);
    qw   = prod[32 +: StepW];
    back = StepW'(qw * StepW'(ClockDivisor));
    res.q = qw[DigitW-1:0];
    res.r = RemW'(x - back);
    return res;
  endfunction

endpackage

FILE: design/crc_regs.sv
// APB configuration registers: uniform mode and DSP ratio numerator.
module crc_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [crc_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic                       uniform_mode,
  output logic [31:0]                dsp_ratio_numerator
);
  import crc_pkg::*;

  typedef enum logic {
    RegUniform = 1'b0,
    RegRatio   = 1'b1
  } reg_idx_t;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[AddrW-1]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      uniform_mode        <= 1'b1;
      dsp_ratio_numerator <= RatioReset;
    end else if (wr) begin
      case (idx)
        RegUniform: uniform_mode        <= pwdata[0];
        RegRatio:   dsp_ratio_numerator <= pwdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegUniform: prdata = {31'b0, uniform_mode};
      RegRatio:   prdata = dsp_ratio_numerator;
      default:    prdata = '0;
    endcase
  end

endmodule

FILE: design/crc_delta.sv
// Sample stage: difference from the previous counter sample and mode decision.
module crc_delta (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [63:0] sample,
  input  logic        uniform_mode,
  output logic [63:0] delta,
  output logic        fb
);
  import crc_pkg::*;

  logic [63:0] prev_sample;
  logic [63:0] sample_m;
  logic [63:0] diff;

  assign sample_m = sample & CntMask;
  assign diff     = (sample_m - prev_sample) & CntMask;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample <= '0;
    end else if (take) begin
      prev_sample <= sample_m;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      delta <= diff;
      fb    <= (diff == '0) || uniform_mode;
    end
  end

endmodule

FILE: design/crc_mul.sv
// Two-stage 64x32 product, kept modulo 2^64.
module crc_mul (
  input  logic        clk,
  input  logic        en_a,
  input  logic        en_b,
  input  logic [63:0] delta,
  input  logic [31:0] ratio,
  output logic [63:0] prod
);
  import crc_pkg::*;

  logic [63:0] pl;
  logic [31:0] ph;

  always_ff @(posedge clk) begin
    if (en_a) begin
      pl <= 64'(delta[31:0]) * 64'(ratio);
      ph <= delta[63:32] * ratio;
    end
    if (en_b) begin
      prod <= pl + {ph, 32'b0};
    end
  end

endmodule

FILE: design/crc_div.sv
// Pipelined long division of a 64-bit word by the clock divisor, one 16-bit digit per stage.
module crc_div (
  input  logic                       clk,
  input  logic [crc_pkg::NumDigits-1:0] en,
  input  logic [63:0]                x,
  output logic [63:0]                q,
  output logic [crc_pkg::RemW-1:0]   r
);
  import crc_pkg::*;

  logic [RemW-1:0] rem_s  [NumDigits];
  logic [63:0]     quo_s  [NumDigits];
  logic [63:0]     num_s  [NumDigits];
  logic [RemW-1:0] rin    [NumDigits];
  logic [63:0]     qin    [NumDigits];
  logic [63:0]     nin    [NumDigits];
  logic [63:0]     qnew   [NumDigits];
  div_step_t       step   [NumDigits];

  always_comb begin
    for (int j = 0; j < NumDigits; j++) begin
      if (j == 0) begin
        rin[j] = '0;
        qin[j] = '0;
        nin[j] = x;
      end else begin
        rin[j] = rem_s[j-1];
        qin[j] = quo_s[j-1];
        nin[j] = num_s[j-1];
      end
      step[j] = div_step(rin[j], nin[j][(NumDigits-1-j)*DigitW +: DigitW]);
      qnew[j] = qin[j];
      qnew[j][(NumDigits-1-j)*DigitW +: DigitW] = step[j].q;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NumDigits; j++) begin
      if (en[j]) begin
        rem_s[j] <= step[j].r;
        quo_s[j] <= qnew[j];
        num_s[j] <= nin[j];
      end
    end
  end

  assign q = quo_s[NumDigits-1];
  assign r = rem_s[NumDigits-1];

endmodule

FILE: design/crc_accum.sv
// Charge accumulation: residue carry, time base and device clock state, result register.
module crc_accum (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     take,
  input  crc_pkg::side_t           side,
  input  logic [63:0]              dq,
  input  logic [crc_pkg::RemW-1:0] dr,
  input  logic [63:0]              pq,
  input  logic [crc_pkg::RemW-1:0] pr,
  input  logic [31:0]              ratio,
  output logic                     derived_flag,
  output logic [31:0]              dsp_charge,
  output logic [31:0]              audio_cycles,
  output logic [63:0]              time_base_now,
  output logic [63:0]              device_clock_now
);
  import crc_pkg::*;

  typedef struct packed {
    logic            wrap;
    logic            carry;
    logic [RemW-1:0] rem;
  } fold_t;

  // (q*d + qr + rs) / d, with the sum wrapping at 64 bits
  function automatic fold_t fold(input logic [RemW-1:0] qr, input logic hi,
                                 input logic [RemW-1:0] neg, input logic [RemW-1:0] rs);
    logic [RemW:0] sum;
    fold_t         f;
    sum = {1'b0, qr} + {1'b0, rs};
    f.wrap  = 1'b0;
    f.carry = 1'b0;
    f.rem   = sum[RemW-1:0];
    if (hi && (rs >= neg)) begin
      f.wrap = 1'b1;
      f.rem  = rs - neg;
    end else if (sum >= (RemW + 1)'(ClockDivisor)) begin
      f.carry = 1'b1;
      f.rem   = RemW'(sum - (RemW + 1)'(ClockDivisor));
    end
    return f;
  endfunction

  logic [63:0]     time_base;
  logic [RemW-1:0] time_base_residue;
  logic [RemW-1:0] dsp_residue;
  logic [63:0]     device_clock;

  logic [63:0]     time_base_next;
  logic [RemW-1:0] time_base_residue_next;
  logic [RemW-1:0] dsp_residue_next;
  logic [63:0]     device_clock_next;
  logic [31:0]     dsp_next;
  logic [63:0]     pquot;
  logic [63:0]     tb_add;
  fold_t           tf;
  fold_t           pf;

  always_comb begin
    tf     = fold(dr, side.d_hi, side.d_neg, time_base_residue);
    pf     = fold(pr, side.p_hi, side.p_neg, dsp_residue);
    tb_add = tf.wrap ? '0 : dq;
    pquot  = pf.wrap ? '0 : (pq + 64'(pf.carry));
    if (side.fb) begin
      time_base_next         = time_base + FbTimeInc;
      device_clock_next      = device_clock + FbClockInc;
      time_base_residue_next = time_base_residue;
      dsp_residue_next       = dsp_residue;
      dsp_next               = ratio;
    end else begin
      time_base_next         = time_base + tb_add + 64'(tf.carry && !tf.wrap);
      device_clock_next      = device_clock + side.delta;
      time_base_residue_next = tf.rem;
      dsp_residue_next       = pf.rem;
      dsp_next               = pquot[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_base         <= '0;
      time_base_residue <= '0;
      dsp_residue       <= '0;
      device_clock      <= '0;
    end else if (take) begin
      time_base         <= time_base_next;
      time_base_residue <= time_base_residue_next;
      dsp_residue       <= dsp_residue_next;
      device_clock      <= device_clock_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      derived_flag     <= !side.fb;
      dsp_charge       <= dsp_next;
      audio_cycles     <= side.fb ? '0 : side.delta[31:0];
      time_base_now    <= time_base_next;
      device_clock_now <= device_clock_next;
    end
  end

endmodule

FILE: design/cycle_ratio_charger_unit.sv
// Top level of the cycle ratio charger.
// Takes one core cycle counter sample per word and returns one charge word per sample,
// in order. Sustained rate is one word per clock while the output is not stalled. The
// sample difference is registered as the word is taken, then the 64x32 product in its
// partial-product and sum registers, then the two 16-bit-digit divider pipelines, then
// the residue and clock accumulation in the output register. Back-pressure stalls only
// as far as the pipeline has no bubbles, so up to eight words can be held. Configuration
// writes must be made only while no word is in flight; the block does not enforce this.
module cycle_ratio_charger_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [63:0]               s_axis_tdata,   // [63:0] core_cycle_count
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [31:0] dsp charge, [63:32] audio_cycles, [127:64] time_base_now,
  // [191:128] device_clock_now
  output logic [191:0]              m_axis_tdata,
  output logic                      m_axis_tuser,   // [0] derived_flag
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [crc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import crc_pkg::*;

  localparam int Stages = 3 + NumDigits;

  logic              uniform_mode;
  logic [31:0]       dsp_ratio_numerator;
  logic [Stages:0]   en;
  logic [Stages-1:0] v;
  logic              take_in;
  logic              take_out;

  logic [63:0]       d0;
  logic              fb0;
  logic [63:0]       d1;
  logic              fb1;
  logic [63:0]       d2;
  logic              fb2;
  logic [63:0]       p2;
  logic [63:0]       neg_d;
  logic [63:0]       neg_p;
  side_t             side_in;
  side_t             side_q [NumDigits];
  logic [63:0]       dq;
  logic [RemW-1:0]   dr;
  logic [63:0]       pq;
  logic [RemW-1:0]   pr;

  crc_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .uniform_mode, .dsp_ratio_numerator
  );

  // stage i may load when empty or when its word moves on
  always_comb begin
    en[Stages] = !m_axis_tvalid || m_axis_tready;
    for (int i = Stages - 1; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign s_axis_tready = en[0];
  assign take_in       = s_axis_tvalid && en[0];
  assign take_out      = en[Stages] && v[Stages-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v             <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (en[0]) v[0] <= take_in;
      for (int i = 1; i < Stages; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
      if (en[Stages]) m_axis_tvalid <= v[Stages-1];
    end
  end

  crc_delta u_delta (
    .clk, .rst, .take(take_in), .sample(s_axis_tdata), .uniform_mode,
    .delta(d0), .fb(fb0)
  );

  crc_mul u_mul (
    .clk, .en_a(en[1]), .en_b(en[2]), .delta(d0), .ratio(dsp_ratio_numerator), .prod(p2)
  );

  always_ff @(posedge clk) begin
    if (en[1]) begin
      d1  <= d0;
      fb1 <= fb0;
    end
    if (en[2]) begin
      d2  <= d1;
      fb2 <= fb1;
    end
  end

  // a sum with a residue wraps only when the value lies within one divisor of 2^64
  always_comb begin
    neg_d         = '0 - d2;
    neg_p         = '0 - p2;
    side_in.fb    = fb2;
    side_in.delta = d2;
    side_in.d_hi  = (d2 != '0) && (neg_d < 64'(ClockDivisor));
    side_in.d_neg = neg_d[RemW-1:0];
    side_in.p_hi  = (p2 != '0) && (neg_p < 64'(ClockDivisor));
    side_in.p_neg = neg_p[RemW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[3]) side_q[0] <= side_in;
    for (int i = 1; i < NumDigits; i++) begin
      if (en[3+i]) side_q[i] <= side_q[i-1];
    end
  end

  crc_div u_div_delta (
    .clk, .en(en[Stages-1:3]), .x(d2), .q(dq), .r(dr)
  );

  crc_div u_div_prod (
    .clk, .en(en[Stages-1:3]), .x(p2), .q(pq), .r(pr)
  );

  crc_accum u_accum (
    .clk, .rst, .take(take_out), .side(side_q[NumDigits-1]),
    .dq, .dr, .pq, .pr, .ratio(dsp_ratio_numerator),
    .derived_flag(m_axis_tuser),
    .dsp_charge(m_axis_tdata[31:0]),
    .audio_cycles(m_axis_tdata[63:32]),
    .time_base_now(m_axis_tdata[127:64]),
    .device_clock_now(m_axis_tdata[191:128])
  );

endmodule

FILE: design/crc_checker.sv
// Port-level checks for the cycle ratio charger, bound to the top level.
module crc_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [191:0]              m_axis_tdata,
  input logic                      m_axis_tuser,
  input logic                      psel,
  input logic                      pwrite,
  input logic [crc_pkg::AddrW-1:0] paddr,
  input logic [31:0]               prdata
);
  import crc_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output word valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled output word changed");

  a_fallback_audio: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[63:32] == 32'd0)
    else $error("fallback word carries audio cycles");

  a_mode_readback: assert property (@(posedge clk) disable iff (rst)
    psel && !pwrite && (paddr == '0) |-> prdata[31:1] == 31'd0)
    else $error("uniform mode readback has stray bits");

endmodule

bind cycle_ratio_charger_unit crc_checker u_crc_checker (.*);
